FILE: sv/sha1_message_digest_macros.svh
// Assertion macros shared by the digest block.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

`ifndef ASSERT_OFF
`define SMD_ASSERT(lbl, clk_i, rst_ni, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define SMD_ASSERT_NORST(lbl, clk_i, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");
`else
`define SMD_ASSERT(lbl, clk_i, rst_ni, prop)
`define SMD_ASSERT_NORST(lbl, clk_i, prop)
`endif

`endif

FILE: sv/smd_pkg.sv
package smd_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] PAD_WORD = 32'h80000000;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] digest_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic start;
    logic reinit;
  } cmp_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_sts_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = H0;
      3'd1: r = H1;
      3'd2: r = H2;
      3'd3: r = H3;
      default: r = H4;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [6:0] rnd);
    word_t r;
    priority if (rnd < 7'd20) begin
      r = K0;
    end else if (rnd < 7'd40) begin
      r = K1;
    end else if (rnd < 7'd60) begin
      r = K2;
    end else begin
      r = K3;
    end
    return r;
  endfunction

  function automatic word_t round_f(input logic [6:0] rnd, input word_t b, input word_t c,
                                    input word_t d);
    word_t r;
    priority if (rnd < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      r = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  // Keeps the valid leading bytes of a short final word and appends the pad byte.
  function automatic word_t pad_short(input word_t w, input logic [2:0] nb);
    word_t r;
    unique case (nb)
      3'd1: r = (w & 32'hFF000000) | 32'h00800000;
      3'd2: r = (w & 32'hFFFF0000) | 32'h00008000;
      3'd3: r = (w & 32'hFFFFFF00) | 32'h00000080;
      default: r = PAD_WORD;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/sha1_message_digest.sv
// Streaming SHA-1: a word that does not complete a block is accepted without a stall.
// Every 16th word starts a compression (80 rounds, one per cycle, then chaining-memory
// read, add and write back for each of the five hash words), and input stalls until it ends.
// The last word adds one push per padding word and one or two compressions; the five
// digest words follow from an output register while the next message is taken.
// Reset (synchronous, active low) restores the initial hash values and clears the counters.
module sha1_message_digest (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  smd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output smd_pkg::out_item_t out_data
);

  smd_pkg::buf_wr_t  buf_wr;
  smd_pkg::cmp_ctl_t cmp_ctl;
  smd_pkg::cmp_sts_t cmp_sts;
  smd_pkg::digest_t  digest;
  logic              out_free;
  logic              out_load;

  smd_msg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .buf_wr   (buf_wr),
    .cmp_ctl  (cmp_ctl),
    .cmp_sts  (cmp_sts),
    .out_free (out_free),
    .out_load (out_load)
  );

  smd_compress u_compress (
    .clk    (clk),
    .rst_n  (rst_n),
    .buf_wr (buf_wr),
    .ctl    (cmp_ctl),
    .sts    (cmp_sts),
    .digest (digest)
  );

  smd_digest_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .digest    (digest),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/smd_msg_ctrl.sv
`include "sha1_message_digest_macros.svh"

module smd_msg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  smd_pkg::in_item_t in_data,
  output smd_pkg::buf_wr_t  buf_wr,
  output smd_pkg::cmp_ctl_t cmp_ctl,
  input  smd_pkg::cmp_sts_t cmp_sts,
  input  logic              out_free,
  output logic              out_load
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic        pad80_r, pad80_nxt;
  logic        len_hi_r, len_hi_nxt;
  logic        msg_end_r, msg_end_nxt;
  logic        final_r, final_nxt;
  logic [2:0]  nb;
  logic        accept;
  logic        push;
  logic [31:0] push_data;

  always_comb begin
    nb          = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
    in_stall    = (state_r != S_IDLE);
    accept      = in_valid && !in_stall;
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    len_nxt     = len_r;
    pad80_nxt   = pad80_r;
    len_hi_nxt  = len_hi_r;
    msg_end_nxt = msg_end_r;
    final_nxt   = final_r;
    push        = 1'b0;
    push_data   = '0;
    cmp_ctl     = '0;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          push = 1'b1;
          if (!in_data.last_word) begin
            push_data = in_data.data_word;
            len_nxt   = len_r + 64'd32;
          end else begin
            len_nxt     = len_r + {58'd0, nb, 3'd0};
            msg_end_nxt = 1'b1;
            state_nxt   = S_PAD;
            if (nb == 3'd4) begin
              push_data = in_data.data_word;
              pad80_nxt = 1'b1;
            end else begin
              push_data = smd_pkg::pad_short(in_data.data_word, nb);
            end
          end
        end
      end
      S_PAD: begin
        push = 1'b1;
        priority if (pad80_r) begin
          push_data = smd_pkg::PAD_WORD;
          pad80_nxt = 1'b0;
        end else if (len_hi_r) begin
          push_data = len_r[31:0];
          final_nxt = 1'b1;
        end else if (fill_r == 4'd14) begin
          push_data  = len_r[63:32];
          len_hi_nxt = 1'b1;
        end else begin
          push_data = '0;
        end
      end
      S_WAIT: begin
        if (cmp_sts.done) begin
          if (final_r) begin
            state_nxt = S_FIN;
          end else if (msg_end_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load       = 1'b1;
          cmp_ctl.reinit = 1'b1;
          state_nxt      = S_IDLE;
          len_nxt        = '0;
          fill_nxt       = '0;
          pad80_nxt      = 1'b0;
          len_hi_nxt     = 1'b0;
          msg_end_nxt    = 1'b0;
          final_nxt      = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (push) begin
      fill_nxt = fill_r + 4'd1;
      if (fill_r == 4'd15) begin
        cmp_ctl.start = 1'b1;
        state_nxt     = S_WAIT;
      end
    end
    buf_wr.en   = push;
    buf_wr.addr = fill_r;
    buf_wr.data = push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      len_r     <= '0;
      pad80_r   <= 1'b0;
      len_hi_r  <= 1'b0;
      msg_end_r <= 1'b0;
      final_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      len_r     <= len_nxt;
      pad80_r   <= pad80_nxt;
      len_hi_r  <= len_hi_nxt;
      msg_end_r <= msg_end_nxt;
      final_r   <= final_nxt;
    end
  end

  `SMD_ASSERT_NORST(a_push_state, clk, buf_wr.en |-> (state_r == S_IDLE) || (state_r == S_PAD))
  `SMD_ASSERT(a_start_busy, clk, rst_n, cmp_ctl.start |=> cmp_sts.busy)

endmodule

FILE: sv/smd_compress.sv
`include "sha1_message_digest_macros.svh"

module smd_compress (
  input  logic              clk,
  input  logic              rst_n,
  input  smd_pkg::buf_wr_t  buf_wr,
  input  smd_pkg::cmp_ctl_t ctl,
  output smd_pkg::cmp_sts_t sts,
  output smd_pkg::digest_t  digest
);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_ROUND = 2'd1;
  localparam logic [1:0] P_UPD   = 2'd2;

  logic [31:0]       buf_mem [16];
  logic [31:0]       chain_mem [5];
  logic [31:0]       buf_rd_r;
  logic [31:0]       chain_rd_r;
  logic [3:0]        buf_raddr;
  logic [2:0]        chain_raddr;

  logic [1:0]        phase_r, phase_nxt;
  logic [6:0]        rnd_r, rnd_nxt;
  logic [2:0]        upd_r, upd_nxt;
  logic              fresh_r, fresh_nxt;
  logic [31:0]       a_r, b_r, c_r, d_r, e_r;
  logic [31:0]       a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [15:0][31:0] sched_r, sched_nxt;
  logic [31:0]       wt, mix, t, chain_in, sum;
  logic              chain_we;

  always_comb begin
    buf_raddr   = (phase_r == P_ROUND) ? rnd_r[3:0] + 4'd1 : 4'd0;
    chain_raddr = (phase_r == P_UPD && upd_r != 3'd4) ? upd_r + 3'd1 : 3'd0;
    mix         = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
    wt          = (rnd_r < 7'd16) ? buf_rd_r : {mix[30:0], mix[31]};
    t           = {a_r[26:0], a_r[31:27]} + smd_pkg::round_f(rnd_r, b_r, c_r, d_r) + e_r
                  + smd_pkg::round_k(rnd_r) + wt;
    chain_in    = fresh_r ? smd_pkg::init_hash(upd_r) : chain_rd_r;
    sum         = chain_in + a_r;
    phase_nxt   = phase_r;
    rnd_nxt     = rnd_r;
    upd_nxt     = upd_r;
    fresh_nxt   = fresh_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    d_nxt       = d_r;
    e_nxt       = e_r;
    sched_nxt   = sched_r;
    chain_we    = 1'b0;
    sts.done    = 1'b0;
    sts.busy    = (phase_r != P_IDLE);
    unique case (phase_r)
      P_IDLE: begin
        if (ctl.reinit) begin
          a_nxt     = smd_pkg::H0;
          b_nxt     = smd_pkg::H1;
          c_nxt     = smd_pkg::H2;
          d_nxt     = smd_pkg::H3;
          e_nxt     = smd_pkg::H4;
          fresh_nxt = 1'b1;
        end else if (ctl.start) begin
          phase_nxt = P_ROUND;
          rnd_nxt   = '0;
        end
      end
      P_ROUND: begin
        sched_nxt = {wt, sched_r[15:1]};
        a_nxt     = t;
        b_nxt     = a_r;
        c_nxt     = {b_r[1:0], b_r[31:2]};
        d_nxt     = c_r;
        e_nxt     = d_r;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          phase_nxt = P_UPD;
          upd_nxt   = '0;
        end
      end
      P_UPD: begin
        chain_we = 1'b1;
        a_nxt    = b_r;
        b_nxt    = c_r;
        c_nxt    = d_r;
        d_nxt    = e_r;
        e_nxt    = sum;
        upd_nxt  = upd_r + 3'd1;
        if (upd_r == 3'd4) begin
          sts.done  = 1'b1;
          phase_nxt = P_IDLE;
          fresh_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
    digest = {e_r, d_r, c_r, b_r, a_r};
  end

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      buf_mem[buf_wr.addr] <= buf_wr.data;
    end
    buf_rd_r <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (chain_we) begin
      chain_mem[upd_r] <= sum;
    end
    chain_rd_r <= chain_mem[chain_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      rnd_r   <= '0;
      upd_r   <= '0;
      fresh_r <= 1'b1;
      a_r     <= smd_pkg::H0;
      b_r     <= smd_pkg::H1;
      c_r     <= smd_pkg::H2;
      d_r     <= smd_pkg::H3;
      e_r     <= smd_pkg::H4;
    end else begin
      phase_r <= phase_nxt;
      rnd_r   <= rnd_nxt;
      upd_r   <= upd_nxt;
      fresh_r <= fresh_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
      d_r     <= d_nxt;
      e_r     <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sched_r <= sched_nxt;
  end

  `SMD_ASSERT(a_start_idle, clk, rst_n, ctl.start |-> phase_r == P_IDLE)
  `SMD_ASSERT(a_last_round, clk, rst_n, (phase_r == P_ROUND) && (rnd_r == 7'd79) |=> (phase_r == P_UPD) && (upd_r == 3'd0))
  `SMD_ASSERT(a_no_write_busy, clk, rst_n, buf_wr.en |-> phase_r == P_IDLE)

endmodule

FILE: sv/smd_digest_out.sv
`include "sha1_message_digest_macros.svh"

module smd_digest_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  smd_pkg::digest_t   digest,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output smd_pkg::out_item_t out_data
);

  smd_pkg::digest_t word_r;
  logic [2:0]       cnt_r;
  logic [2:0]       idx_r;
  logic             take;

  always_comb begin
    free                 = (cnt_r == 3'd0);
    out_valid            = (cnt_r != 3'd0);
    take                 = out_valid && !out_stall;
    out_data.digest_word = word_r[0];
    out_data.word_index  = idx_r;
    out_data.digest_end  = (cnt_r == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= 3'd5;
      idx_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= digest;
    end else if (take) begin
      word_r <= {32'd0, word_r[4:1]};
    end
  end

  `SMD_ASSERT(a_load_free, clk, rst_n, load |-> cnt_r == 3'd0)

endmodule

FILE: verif/digest_sb_pkg.sv
`timescale 1ns / 100ps

package digest_sb_pkg;
  import smd_pkg::*;

  class digest_scoreboard;
    word_t           chain[5];
    word_t           blk_words[16];
    int unsigned     blk_fill;
    logic [63:0]     msg_bits;
    out_item_t       pending[$];
    int unsigned     failures;
    int unsigned     words_taken;
    int unsigned     messages_done;
    int unsigned     digest_words_checked;

    function new();
      failures = 0;
      words_taken = 0;
      messages_done = 0;
      digest_words_checked = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = H0;
      chain[1] = H1;
      chain[2] = H2;
      chain[3] = H3;
      chain[4] = H4;
      foreach (blk_words[i]) blk_words[i] = '0;
      blk_fill = 0;
      msg_bits = '0;
    endfunction

    function word_t rotl(word_t x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      word_t sched[80];
      word_t a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) sched[i] = blk_words[i];
      for (int i = 16; i < 80; i++) begin
        sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        t = rotl(a, 5) + f + e + k + sched[i];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb(word_t w);
      blk_words[blk_fill] = w;
      blk_fill++;
      if (blk_fill == 16) begin
        compress();
        blk_fill = 0;
      end
    endfunction

    function void note_word(in_item_t it);
      int unsigned nb;
      word_t       mask;
      out_item_t   res;
      words_taken++;
      nb = (it.valid_bytes > 3'd4) ? 4 : it.valid_bytes;
      if (!it.last_word) begin
        msg_bits += 64'd32;
        absorb(it.data_word);
        return;
      end
      msg_bits += 64'(8 * nb);
      if (nb == 0) begin
        absorb(PAD_WORD);
      end else if (nb == 4) begin
        absorb(it.data_word);
        absorb(PAD_WORD);
      end else begin
        mask = 32'hFFFF_FFFF << (32 - 8 * nb);
        absorb((it.data_word & mask) | (32'h80 << (24 - 8 * nb)));
      end
      if (blk_fill > 14) absorb('0);
      while (blk_fill != 14) absorb('0);
      absorb(msg_bits[63:32]);
      absorb(msg_bits[31:0]);
      for (int j = 0; j < 5; j++) begin
        res.digest_word = chain[j];
        res.word_index = 3'(j);
        res.digest_end = (j == 4);
        pending = {pending, res};
      end
      messages_done++;
      restart();
    endfunction

    function void check_digest_word(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] unexpected digest word %h index %0d end %b", $time,
                   got.digest_word, got.word_index, got.digest_end);
        end
        return;
      end
      want = pending.pop_front();
      digest_words_checked++;
      if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
          got.digest_end !== want.digest_end) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] digest mismatch: expected word %h index %0d end %b, got %h %0d %b",
                   $time, want.digest_word, want.word_index, want.digest_end,
                   got.digest_word, got.word_index, got.digest_end);
        end
      end
    endfunction
  endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import smd_pkg::*;
  import digest_sb_pkg::*;

  localparam int unsigned RANDOM_WORDS = 155;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 300;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic      steady = 1'b0;
  logic      hold_go = 1'b0;

  digest_scoreboard sb;

  sha1_message_digest u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input word_t data, input logic [2:0] vb, input logic last);
    in_item_t item;
    item.data_word = data;
    item.valid_bytes = vb;
    item.last_word = last;
    if (!steady) begin
      while ($urandom_range(0, 99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(item);
  endtask

  task automatic send_message(input int unsigned full_words);
    logic [2:0] vb;
    for (int unsigned i = 0; i < full_words; i++) begin
      vb = ($urandom_range(0, 99) < 20) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, vb, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_digest_word(out_data);
  end

  initial begin : receiver
    bit hold_taken;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 14);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    int unsigned rand_words;
    int unsigned len;
    int unsigned r;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, then single-word messages with byte counts 1 to 5 and 7 on the final word.
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'hA5C3_0F96, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word(32'h1234_5678, 3'd5, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    // Short byte counts on words that are not final are taken as full words.
    send_word(32'hDEAD_BEEF, 3'd1, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_word(32'h0102_0304, 3'd6, 1'b1);
    // Thirteen words and a full final word push the padding into an extra block.
    for (int i = 0; i < 13; i++) begin
      send_word((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0);
    end
    send_word(32'h8000_0001, 3'd4, 1'b1);

    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      steady <= (rand_words >= 40 && rand_words < 90);
      if (rand_words >= 100) hold_go <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 65) len = $urandom_range(0, 12);
      else if (r < 85) len = $urandom_range(13, 16);
      else len = $urandom_range(17, 40);
      send_message(len);
      rand_words += len + 1;
    end
    in_valid <= 1'b0;
    steady <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d messages; checked %0d digest words, %0d failures.",
             sb.words_taken, sb.messages_done, sb.digest_words_checked, sb.failures);
    $display("Covered empty and short final words, extra pad blocks, gaps and a long hold-off.");
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/smd_pkg.sv
sv/smd_msg_ctrl.sv
sv/smd_compress.sv
sv/smd_digest_out.sv
sv/sha1_message_digest.sv
verif/digest_sb_pkg.sv
verif/tb_top.sv
